@@ rtl/ddpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpm_pkg
// shared widths, constants, types and helpers of the degree-day melt pipeline
// ----------------------------------------------------------------------------
package ddpm_pkg;

    localparam int ANG_W        = 18;
    localparam int XY_W         = 19;
    localparam int Z_W          = 16;
    localparam int TRIG_W       = 14;
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;
    localparam int PIPE_DEPTH   = CORDIC_DEPTH + 8;
    localparam int CFG_DATA_W   = 13;
    localparam int MELT_W       = 22;

    localparam logic signed [ANG_W-1:0] PI_Q13       = 18'sd25736;
    localparam logic signed [ANG_W-1:0] NEG_PI_Q13   = -18'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13  = 18'sd12868;
    localparam logic signed [ANG_W-1:0] NEG_HALF_PI  = -18'sd12868;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q13   = 18'sd51472;
    localparam logic signed [ANG_W-1:0] SOLSTICE_Q13 = 18'sd50062;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 19'sd39797;
    localparam logic signed [XY_W:0]   CLAMP_HI  = 20'sd4096;
    localparam logic signed [XY_W:0]   CLAMP_LO  = -20'sd4096;

    localparam logic [28:0] U_SAT   = 29'd419430399;
    localparam logic [41:0] U_KNEE  = 42'd419430349;
    localparam logic [28:0] U_BIAS  = 29'd50;
    localparam logic [29:0] RECIP   = 30'd687194768;

    typedef enum logic [0:0] {
        REG_ASPECT_STRENGTH = 1'b0,
        REG_MELT_THRESHOLD  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [14:0]        factor_max;
        logic [14:0]        factor_min;
        logic [13:0]        forest_factor;
        logic [12:0]        forest_share;
        logic signed [13:0] air_temp;
        logic               last_cell;
    } side_t;

    typedef struct packed {
        logic [MELT_W-1:0] potential_melt;
        logic              last_out;
    } result_t;

    function automatic logic signed [Z_W-1:0] atan_q13(input int unsigned i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 16'sd6434;
            1:       r = 16'sd3798;
            2:       r = 16'sd2007;
            3:       r = 16'sd1019;
            4:       r = 16'sd511;
            5:       r = 16'sd256;
            6:       r = 16'sd128;
            7:       r = 16'sd64;
            8:       r = 16'sd32;
            9:       r = 16'sd16;
            10:      r = 16'sd8;
            11:      r = 16'sd4;
            12:      r = 16'sd2;
            13:      r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    // round q16 to q12 and clamp to one
    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        logic signed [TRIG_W-1:0] r;
        t = ((XY_W+1)'(v) + (XY_W+1)'(8)) >>> 4;
        if (t > CLAMP_HI)
            r = TRIG_W'(CLAMP_HI);
        else if (t < CLAMP_LO)
            r = TRIG_W'(CLAMP_LO);
        else
            r = TRIG_W'(t);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/ddpm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpm_if
// request channels of the melt block: grid cells in, melt results out
// ----------------------------------------------------------------------------
interface ddpm_in_if;
    logic               valid;
    logic               ready;
    logic [14:0]        factor_max;
    logic [14:0]        factor_min;
    logic [13:0]        forest_factor;
    logic [12:0]        forest_share;
    logic signed [14:0] latitude;
    logic [13:0]        slope_angle;
    logic [15:0]        aspect_angle;
    logic signed [13:0] air_temp;
    logic [15:0]        day_angle;
    logic               last_cell;

    modport source (
        output valid, factor_max, factor_min, forest_factor, forest_share, latitude,
               slope_angle, aspect_angle, air_temp, day_angle, last_cell,
        input  ready
    );
    modport sink (
        input  valid, factor_max, factor_min, forest_factor, forest_share, latitude,
               slope_angle, aspect_angle, air_temp, day_angle, last_cell,
        output ready
    );
endinterface

interface ddpm_out_if;
    logic        valid;
    logic        ready;
    logic [21:0] potential_melt;
    logic        last_out;

    modport source (output valid, potential_melt, last_out, input ready);
    modport sink (input valid, potential_melt, last_out, output ready);
endinterface
`default_nettype wire

@@ rtl/degree_day_potential_melt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// degree_day_potential_melt
// potential snowmelt per grid cell from a seasonal degree-day factor
// ----------------------------------------------------------------------------
//  channel   dir   contents
//  grid      in    one grid cell request
//  result    out   potential melt and last-cell flag
//  cfg       in    register writes, no read-back
//
//  one cell per cycle while the skid is empty; grid.ready is low while it holds a result
//  depth: 16 cordic stages, 8 arithmetic stages, output register
//  reset clears valid bits, skid valid and config registers; no clearing pass
//  a stalled result parks in a one-entry skid, the pipe halts only once it fills
// ----------------------------------------------------------------------------
module degree_day_potential_melt (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire ddpm_pkg::reg_index_t                cfg_index,
    input  wire logic [ddpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    ddpm_in_if.sink                                  grid,
    ddpm_out_if.source                               result
);
    import ddpm_pkg::*;

    logic [12:0]        aspect_strength_reg;
    logic signed [10:0] melt_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aspect_strength_reg <= '0;
            melt_threshold_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ASPECT_STRENGTH: aspect_strength_reg <= cfg_data[12:0];
                REG_MELT_THRESHOLD:  melt_threshold_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    result_t pipe_res;

    assign en         = !skid_valid_reg;
    assign grid.ready = en;

    // angle arguments; day and aspect shifted by pi in the southern hemisphere
    logic signed [ANG_W-1:0] adj;
    logic signed [ANG_W-1:0] day_arg;
    logic signed [ANG_W-1:0] aspect_arg;
    logic signed [ANG_W-1:0] slope_arg;

    assign adj        = grid.latitude[14] ? PI_Q13 : '0;
    assign day_arg    = $signed({2'b0, grid.day_angle}) - SOLSTICE_Q13 - adj;
    assign aspect_arg = $signed({2'b0, grid.aspect_angle}) - adj;
    assign slope_arg  = $signed({4'b0, grid.slope_angle});

    side_t side_in;
    side_t side_reg [0:CORDIC_DEPTH-1];

    assign side_in = '{factor_max:    grid.factor_max,
                       factor_min:    grid.factor_min,
                       forest_factor: grid.forest_factor,
                       forest_share:  grid.forest_share,
                       air_temp:      grid.air_temp,
                       last_cell:     grid.last_cell};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < CORDIC_DEPTH; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    logic signed [TRIG_W-1:0] cos_day;
    logic signed [TRIG_W-1:0] sin_slope;
    logic signed [TRIG_W-1:0] cos_aspect;

    ddpm_cordic u_cordic_day (
        .clk     (clk),
        .en      (en),
        .angle   (day_arg),
        .cos_q12 (cos_day),
        .sin_q12 ()
    );

    ddpm_cordic u_cordic_slope (
        .clk     (clk),
        .en      (en),
        .angle   (slope_arg),
        .cos_q12 (),
        .sin_q12 (sin_slope)
    );

    ddpm_cordic u_cordic_aspect (
        .clk     (clk),
        .en      (en),
        .angle   (aspect_arg),
        .cos_q12 (cos_aspect),
        .sin_q12 ()
    );

    ddpm_melt u_melt (
        .clk             (clk),
        .en              (en),
        .cos_day         (cos_day),
        .sin_slope       (sin_slope),
        .cos_aspect      (cos_aspect),
        .side            (side_reg[CORDIC_DEPTH-1]),
        .aspect_strength (aspect_strength_reg),
        .melt_threshold  (melt_threshold_reg),
        .potential_melt  (pipe_res.potential_melt),
        .last_out        (pipe_res.last_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[PIPE_DEPTH-2:0], grid.valid};
    end

    // output register with one-entry skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (v_reg[PIPE_DEPTH-1])
        begin
            if (!out_valid_reg || result.ready)
            begin
                out_next       = pipe_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = pipe_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.potential_melt = out_reg.potential_melt;
    assign result.last_out       = out_reg.last_out;

endmodule
`default_nettype wire

@@ rtl/ddpm_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpm_cordic
// pipelined sine/cosine: range reduction, one rotation per stage, clamp
// ----------------------------------------------------------------------------
module ddpm_cordic (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [ddpm_pkg::ANG_W-1:0] angle,
    output logic signed [ddpm_pkg::TRIG_W-1:0]     cos_q12,
    output logic signed [ddpm_pkg::TRIG_W-1:0]     sin_q12
);
    import ddpm_pkg::*;

    logic signed [ANG_W-1:0] a_wrap;
    logic signed [ANG_W-1:0] a_fold;
    logic                    fold_neg;

    logic signed [Z_W-1:0]   z0_reg;
    logic [CORDIC_STEPS:0]   neg_reg;

    logic signed [XY_W-1:0]  x_cur [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  y_cur [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]   z_cur [0:CORDIC_STEPS];

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_comb
    begin
        if (angle > PI_Q13)
            a_wrap = angle - TWO_PI_Q13;
        else if (angle <= NEG_PI_Q13)
            a_wrap = angle + TWO_PI_Q13;
        else
            a_wrap = angle;
        fold_neg = 1'b0;
        a_fold   = a_wrap;
        if (a_wrap > HALF_PI_Q13)
        begin
            a_fold   = a_wrap - PI_Q13;
            fold_neg = 1'b1;
        end
        else if (a_wrap < NEG_HALF_PI)
        begin
            a_fold   = a_wrap + PI_Q13;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg  <= Z_W'(a_fold);
            neg_reg <= {neg_reg[CORDIC_STEPS-1:0], fold_neg};
        end
    end

    assign x_cur[0] = CORDIC_X0;
    assign y_cur[0] = '0;
    assign z_cur[0] = z0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [XY_W-1:0] x_reg;
        logic signed [XY_W-1:0] y_reg;
        logic signed [Z_W-1:0]  z_reg;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        assign xs = x_cur[i] >>> i;
        assign ys = y_cur[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_cur[i][Z_W-1])
                begin
                    x_reg <= x_cur[i] - ys;
                    y_reg <= y_cur[i] + xs;
                    z_reg <= z_cur[i] - atan_q13(i);
                end
                else
                begin
                    x_reg <= x_cur[i] + ys;
                    y_reg <= y_cur[i] - xs;
                    z_reg <= z_cur[i] + atan_q13(i);
                end
            end
        end

        assign x_cur[i+1] = x_reg;
        assign y_cur[i+1] = y_reg;
        assign z_cur[i+1] = z_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= clamp_unit(neg_reg[CORDIC_STEPS] ? -x_cur[CORDIC_STEPS]
                                                         : x_cur[CORDIC_STEPS]);
            sin_reg <= clamp_unit(neg_reg[CORDIC_STEPS] ? -y_cur[CORDIC_STEPS]
                                                         : y_cur[CORDIC_STEPS]);
        end
    end

    assign cos_q12 = cos_reg;
    assign sin_q12 = sin_reg;

endmodule
`default_nettype wire

@@ rtl/ddpm_melt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpm_melt
// melt factor, forest and aspect corrections, product and scaling, 8 stages
// ----------------------------------------------------------------------------
module ddpm_melt (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [ddpm_pkg::TRIG_W-1:0] cos_day,
    input  wire logic signed [ddpm_pkg::TRIG_W-1:0] sin_slope,
    input  wire logic signed [ddpm_pkg::TRIG_W-1:0] cos_aspect,
    input  wire ddpm_pkg::side_t                    side,
    input  wire logic [12:0]                        aspect_strength,
    input  wire logic signed [10:0]                 melt_threshold,
    output logic [ddpm_pkg::MELT_W-1:0]             potential_melt,
    output logic                                    last_out
);
    import ddpm_pkg::*;

    // stage 1
    logic signed [14:0] w_reg;
    logic signed [15:0] d_reg;
    logic [14:0]        fmin1_reg;
    logic signed [16:0] fq1_reg;
    logic signed [15:0] sc_reg;
    logic signed [TRIG_W-1:0] ca1_reg;
    logic signed [13:0] temp1_reg;
    logic [7:0]         last_reg;

    logic signed [13:0] rest;
    logic signed [28:0] fcm;
    logic signed [28:0] fcs;
    logic signed [28:0] fq_sum;
    logic signed [28:0] sc_sum;

    assign rest   = 14'sd4096 - $signed({1'b0, side.forest_share});
    assign fcm    = $signed({1'b0, side.forest_share}) * $signed({1'b0, side.forest_factor});
    assign fcs    = $signed({1'b0, side.forest_share}) * sin_slope;
    assign fq_sum = (29'(rest) <<< 12) + fcm + 29'sd2048;
    assign sc_sum = (29'(rest) <<< 12) + fcs + 29'sd2048;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= 15'sd4096 - 15'(cos_day);
            d_reg     <= $signed({1'b0, side.factor_max}) - $signed({1'b0, side.factor_min});
            fmin1_reg <= side.factor_min;
            fq1_reg   <= fq_sum[28:12];
            sc_reg    <= sc_sum[27:12];
            ca1_reg   <= cos_aspect;
            temp1_reg <= side.air_temp;
            last_reg  <= {last_reg[6:0], side.last_cell};
        end
    end

    // stage 2
    logic signed [30:0] pma_reg;
    logic signed [29:0] asc_reg;
    logic signed [14:0] dt2_reg;
    logic [14:0]        fmin2_reg;
    logic signed [16:0] fq2_reg;
    logic signed [TRIG_W-1:0] ca2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pma_reg   <= d_reg * w_reg;
            asc_reg   <= $signed({1'b0, aspect_strength}) * sc_reg;
            dt2_reg   <= 15'(temp1_reg) - 15'(melt_threshold);
            fmin2_reg <= fmin1_reg;
            fq2_reg   <= fq1_reg;
            ca2_reg   <= ca1_reg;
        end
    end

    // stage 3
    logic signed [31:0] ma_round;
    logic signed [16:0] ma_reg;
    logic signed [43:0] t_reg;
    logic signed [16:0] fq3_reg;
    logic signed [14:0] dt3_reg;

    assign ma_round = 32'(pma_reg) + 32'sd4096;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg  <= $signed({2'b0, fmin2_reg}) + $signed(ma_round[29:13]);
            t_reg   <= asc_reg * ca2_reg;
            fq3_reg <= fq2_reg;
            dt3_reg <= dt2_reg;
        end
    end

    // stage 4
    logic signed [44:0] t_round;
    logic signed [21:0] af_raw;
    logic [15:0]        af_reg;
    logic signed [33:0] mf4_reg;
    logic signed [14:0] dt4_reg;

    assign t_round = 45'(t_reg) + 45'sd8388608;
    assign af_raw  = 22'sd4096 - 22'($signed(t_round[44:24]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            af_reg  <= af_raw[21] ? 16'd0 : af_raw[15:0];
            mf4_reg <= ma_reg * fq3_reg;
            dt4_reg <= dt3_reg;
        end
    end

    // stage 5
    logic signed [31:0] ad_reg;
    logic signed [33:0] mf5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_reg  <= $signed({1'b0, af_reg}) * dt4_reg;
            mf5_reg <= mf4_reg;
        end
    end

    // stage 6
    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= mf5_reg * ad_reg;
    end

    // stage 7: drop 2^24, round and saturate ahead of the divide by 100
    logic [28:0] u_next;
    logic [28:0] u_reg;
    logic [41:0] hi;

    assign hi = p_reg[65:24];

    always_comb
    begin
        if (p_reg[65] || (p_reg == '0))
            u_next = '0;
        else if (hi > U_KNEE)
            u_next = U_SAT;
        else
            u_next = hi[28:0] + U_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            u_reg <= u_next;
    end

    // stage 8: divide by 100 through the reciprocal
    logic [58:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= u_reg * RECIP;
    end

    assign potential_melt = q_reg[57:36];
    assign last_out       = last_reg[7];

endmodule
`default_nettype wire

@@ bench/tb_degree_day_potential_melt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degree_day_potential_melt_if
// the grid and result channels are the interfaces of rtl/ddpm_if.sv;
// this file only gathers the request record the bench builds per cell
// ----------------------------------------------------------------------------
package tb_ddpm_types;

    typedef struct {
        logic [14:0]        factor_max;
        logic [14:0]        factor_min;
        logic [13:0]        forest_factor;
        logic [12:0]        forest_share;
        logic signed [14:0] latitude;
        logic [13:0]        slope_angle;
        logic [15:0]        aspect_angle;
        logic signed [13:0] air_temp;
        logic [15:0]        day_angle;
        logic               last_cell;
    } cell_t;

endpackage

@@ bench/tb_degree_day_potential_melt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degree_day_potential_melt
// streams grid cells through the melt pipeline under several idle and stall
// mixes and compares every result against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module tb_degree_day_potential_melt;
    import ddpm_pkg::*;
    import tb_ddpm_types::*;

    localparam int LATENCY = 25;

    class melt_scoreboard;
        logic [21:0]  melt_q[$];
        logic         last_q[$];
        int           errors;
        logic [12:0]  strength;
        logic signed [10:0] threshold;

        function new();
            errors = 0;
            strength = 0;
            threshold = 0;
        endfunction

        static function longint fl_shr(longint v, int n);
            return v >>> n;
        endfunction

        static function void trig(longint a, output longint c, output longint s);
            longint x, y, z, nx;
            bit neg;
            longint atan_tab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                     32, 16, 8, 4, 2, 1};
            x = 39797;
            y = 0;
            neg = 0;
            while (a > 25736) a -= 51472;
            while (a <= -25736) a += 51472;
            if (a > 12868)
            begin
                a -= 25736;
                neg = 1;
            end
            else if (a < -12868)
            begin
                a += 25736;
                neg = 1;
            end
            z = a;
            for (int i = 0; i < 14; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - fl_shr(y, i);
                    y = y + fl_shr(x, i);
                    z -= atan_tab[i];
                end
                else
                begin
                    nx = x + fl_shr(y, i);
                    y = y - fl_shr(x, i);
                    z += atan_tab[i];
                end
                x = nx;
            end
            if (neg)
            begin
                x = -x;
                y = -y;
            end
            c = fl_shr(x + 8, 4);
            s = fl_shr(y + 8, 4);
            if (c > 4096) c = 4096;
            if (c < -4096) c = -4096;
            if (s > 4096) s = 4096;
            if (s < -4096) s = -4096;
        endfunction

        function void note_cell(cell_t cl);
            longint adj, cd, sd, cs, ss, ca, sa, w, ma, fq, sc, af, dt, p, fc, m;
            fc = cl.forest_share;
            adj = (cl.latitude < 0) ? 25736 : 0;
            trig(longint'(cl.day_angle) - 50062 - adj, cd, sd);
            trig(longint'(cl.slope_angle), cs, ss);
            trig(longint'(cl.aspect_angle) - adj, ca, sa);
            w = 4096 - cd;
            ma = longint'(cl.factor_min) + fl_shr((longint'(cl.factor_max)
                 - longint'(cl.factor_min)) * w + 4096, 13);
            fq = fl_shr((4096 - fc) * 4096 + fc * cl.forest_factor + 2048, 12);
            sc = fl_shr((4096 - fc) * 4096 + fc * ss + 2048, 12);
            af = 4096 - fl_shr(longint'(strength) * sc * ca + (longint'(1) << 23), 24);
            if (af < 0) af = 0;
            dt = longint'(cl.air_temp) - longint'(threshold);
            p = ma * fq * af * dt;
            if (p <= 0)
                m = 0;
            else
            begin
                m = (p + 838860800) / 1677721600;
                if (m > 4194303) m = 4194303;
            end
            melt_q.push_back(m[21:0]);
            last_q.push_back(cl.last_cell);
        endfunction

        function void check_result(logic [21:0] melt, logic last);
            if (melt_q.size() == 0)
            begin
                $display("%0t unexpected result melt=%0d last=%0b", $time, melt, last);
                errors++;
                return;
            end
            if (melt !== melt_q[0])
            begin
                $display("%0t melt mismatch expected=%0d actual=%0d", $time, melt_q[0], melt);
                errors++;
            end
            if (last !== last_q[0])
            begin
                $display("%0t last mismatch expected=%0b actual=%0b", $time, last_q[0], last);
                errors++;
            end
            void'(melt_q.pop_front());
            void'(last_q.pop_front());
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    reg_index_t  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int          send_idle;
    int          stall;

    ddpm_in_if  grid ();
    ddpm_out_if result ();

    melt_scoreboard board;

    degree_day_potential_melt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grid      (grid),
        .result    (result)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            board.check_result(result.potential_melt, result.last_out);
        if (rst_n && grid.valid && grid.ready)
            ;
        result.ready <= ($urandom_range(99) >= stall);
    end

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_ASPECT_STRENGTH)
            board.strength = val;
        else
            board.threshold = val[10:0];
        @(posedge clk);
    endtask

    task automatic send_cell(cell_t cl);
        while ($urandom_range(99) < send_idle)
        begin
            grid.valid <= 0;
            @(posedge clk);
        end
        grid.valid         <= 1;
        grid.factor_max    <= cl.factor_max;
        grid.factor_min    <= cl.factor_min;
        grid.forest_factor <= cl.forest_factor;
        grid.forest_share  <= cl.forest_share;
        grid.latitude      <= cl.latitude;
        grid.slope_angle   <= cl.slope_angle;
        grid.aspect_angle  <= cl.aspect_angle;
        grid.air_temp      <= cl.air_temp;
        grid.day_angle     <= cl.day_angle;
        grid.last_cell     <= cl.last_cell;
        do
            @(posedge clk);
        while (!grid.ready);
        board.note_cell(cl);
    endtask

    task automatic go_idle();
        grid.valid <= 0;
        while (board.melt_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic cell_t random_cell(bit wide);
        cell_t cl;
        cl.factor_max    = wide ? 15'($urandom) : 15'($urandom_range(20000));
        cl.factor_min    = wide ? 15'($urandom) : 15'($urandom_range(20000));
        cl.forest_factor = wide ? 14'($urandom) : 14'($urandom_range(8192));
        cl.forest_share  = wide ? 13'($urandom) : 13'($urandom_range(4096));
        cl.latitude      = wide ? 15'($urandom)
                                : 15'(int'($urandom_range(18000)) - 9000);
        cl.slope_angle   = wide ? 14'($urandom) : 14'($urandom_range(12868));
        cl.aspect_angle  = wide ? 16'($urandom) : 16'($urandom_range(51472));
        cl.air_temp      = wide ? 14'($urandom)
                                : 14'(int'($urandom_range(12000)) - 6000);
        cl.day_angle     = wide ? 16'($urandom) : 16'($urandom_range(51472));
        cl.last_cell     = 1'($urandom);
        return cl;
    endfunction

    initial
    begin
        cell_t cl;
        logic [12:0] strengths[4] = '{13'd0, 13'd4096, 13'd8191, 13'd1500};
        logic [12:0] thresholds[4] = '{13'h1C18, 13'd1000, 13'd0, 13'h07FF};
        int idles[4] = '{0, 55, 0, 29};
        int stalls[4] = '{0, 0, 55, 29};
        board = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_ASPECT_STRENGTH;
        cfg_data = 0;
        send_idle = 0;
        stall = 0;
        grid.valid = 0;
        grid.factor_max = 0;
        grid.factor_min = 0;
        grid.forest_factor = 0;
        grid.forest_share = 0;
        grid.latitude = 0;
        grid.slope_angle = 0;
        grid.aspect_angle = 0;
        grid.air_temp = 0;
        grid.day_angle = 0;
        grid.last_cell = 0;
        result.ready = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed extremes at reset settings, then full-strength aspect, then also a melt threshold of -1000
        for (int k = 0; k < 24; k++)
        begin
            cl = random_cell(0);
            case (k % 8)
                0: begin cl.factor_max = 20000; cl.factor_min = 20000; cl.air_temp = 6000;
                         cl.forest_share = 0; end
                1: begin cl.factor_max = 0; cl.factor_min = 20000; end
                2: begin cl.factor_max = 15'h7FFF; cl.factor_min = 0; cl.forest_factor = 14'h3FFF;
                         cl.forest_share = 13'h1FFF; cl.air_temp = 14'h1FFF; end
                3: begin cl.latitude = -9000; cl.day_angle = 0; cl.aspect_angle = 16'hFFFF; end
                4: begin cl.latitude = 9000; cl.day_angle = 51472; cl.slope_angle = 14'h3FFF; end
                5: begin cl.air_temp = -6000; cl.latitude = 15'h4000; end
                6: begin cl.slope_angle = 12868; cl.aspect_angle = 25736; cl.forest_share = 4096;
                         cl.forest_factor = 0; end
                default: cl.air_temp = 14'h2000;
            endcase
            if (k == 8) begin go_idle(); write_reg(REG_ASPECT_STRENGTH, 13'd8191); end
            if (k == 16) begin go_idle(); write_reg(REG_MELT_THRESHOLD, 13'h1C18); end
            send_cell(cl);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            go_idle();
            write_reg(REG_ASPECT_STRENGTH, strengths[ph]);
            write_reg(REG_MELT_THRESHOLD, thresholds[ph]);
            send_idle = idles[ph];
            stall = stalls[ph];
            for (int k = 0; k < 220; k++)
            begin
                if (ph == 1 && k == 110)
                    go_idle();
                send_cell(random_cell($urandom_range(9) == 0));
            end
        end

        go_idle();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ degree_day_potential_melt.f @@
rtl/ddpm_pkg.sv
rtl/ddpm_if.sv
rtl/ddpm_cordic.sv
rtl/ddpm_melt.sv
rtl/degree_day_potential_melt.sv
bench/tb_degree_day_potential_melt_if.sv
bench/tb_degree_day_potential_melt.sv
